// ===== hw/rtl/obx_pkg.sv =====
// Shared types, widths, register codes and arithmetic helpers for the oriented box accumulator.
package obx_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int AMT_W     = 32;
    localparam int CMD_W     = 2;

    localparam int COEF_W  = FRAC_BITS + 2;
    localparam int ROW_W   = 3 * COEF_W;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = COEF_W + DIFF_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int EXT_W   = COORD_W + 1;
    localparam int IPROD_W = AMT_W + EXT_W;
    localparam int SAT_W   = IPROD_W + 1;

    localparam int CFG_IDX_W = 3;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [ROW_W-1:0] ROT_ROW0_RST = ROW_W'(64'd262144);
    localparam logic [ROW_W-1:0] ROT_ROW1_RST = ROW_W'(64'd17179869184);
    localparam logic [ROW_W-1:0] ROT_ROW2_RST = ROW_W'(64'd4503599627370496);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD     = 2'd0,
        CMD_TEST    = 2'd1,
        CMD_GROW    = 2'd2,
        CMD_INFLATE = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_ROW0 = 3'd0,
        REG_ROT_ROW1 = 3'd1,
        REG_ROT_ROW2 = 3'd2,
        REG_ORIGIN_X = 3'd3,
        REG_ORIGIN_Y = 3'd4,
        REG_ORIGIN_Z = 3'd5
    } cfg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [AMT_W-1:0]   amount_t;
    typedef logic [ROW_W-1:0]          rot_row_t;

    // One classified item on its way from the transform pipeline to the box update.
    typedef struct packed {
        cmd_t    cmd;
        coord_t  loc_x;
        coord_t  loc_y;
        coord_t  loc_z;
        amount_t amount;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Drop the fraction bits, rounding half toward plus infinity.
    function automatic logic signed [SAT_W-1:0] round_frac(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] half;
        logic signed [SAT_W-1:0] biased;
        half = '0;
        half[FRAC_BITS-1] = 1'b1;
        biased = v + half;
        return biased >>> FRAC_BITS;
    endfunction

    // Clamp a wide signed value into the coordinate range.
    function automatic coord_t sat_coord(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'($signed({1'b0, {(COORD_W-1){1'b1}}}));
        lo = SAT_W'($signed({1'b1, {(COORD_W-1){1'b0}}}));
        if (v > hi) begin
            return hi[COORD_W-1:0];
        end else if (v < lo) begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/obx_front.sv =====
// Front end: input handshake, credit tracking and the pipelined frame transform.
module obx_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [obx_pkg::CMD_W-1:0]  s_command,
    input  obx_pkg::coord_t            s_point_x,
    input  obx_pkg::coord_t            s_point_y,
    input  obx_pkg::coord_t            s_point_z,
    input  obx_pkg::amount_t           s_amount,
    input  obx_pkg::rot_row_t          rot_row0,
    input  obx_pkg::rot_row_t          rot_row1,
    input  obx_pkg::rot_row_t          rot_row2,
    input  obx_pkg::coord_t            origin_x,
    input  obx_pkg::coord_t            origin_y,
    input  obx_pkg::coord_t            origin_z,
    input  logic                       job_pop,
    output logic                       job_push,
    output obx_pkg::job_t              job_out
);
    import obx_pkg::*;

    logic               accept;
    logic [FIFO_CW-1:0] credit_reg;
    logic [FIFO_CW-1:0] credit_next;

    logic                     va_reg;
    cmd_t                     cmd_a_reg;
    amount_t                  amt_a_reg;
    logic signed [DIFF_W-1:0] diff_a_reg  [3];
    logic signed [DIFF_W-1:0] diff_a_next [3];

    logic                     vb_reg;
    cmd_t                     cmd_b_reg;
    amount_t                  amt_b_reg;
    logic signed [PROD_W-1:0] prod_b_reg  [3][3];
    logic signed [PROD_W-1:0] prod_b_next [3][3];

    logic                     vc_reg;
    job_t                     job_c_reg;
    job_t                     job_c_next;

    logic signed [COEF_W-1:0] coef [3][3];
    logic signed [ACC_W-1:0]  acc  [3];
    coord_t                   loc  [3];

    // Every item holds a credit from acceptance until the box update takes it from the queue.
    assign s_ready = (credit_reg < FIFO_CW'(FIFO_DEPTH));
    assign accept  = s_valid && s_ready;

    always_comb begin
        credit_next = credit_reg;
        if (accept && !job_pop) begin
            credit_next = credit_reg + FIFO_CW'(1);
        end else if (!accept && job_pop) begin
            credit_next = credit_reg - FIFO_CW'(1);
        end
    end

    always_comb begin
        diff_a_next[0] = DIFF_W'(s_point_x) - DIFF_W'(origin_x);
        diff_a_next[1] = DIFF_W'(s_point_y) - DIFF_W'(origin_y);
        diff_a_next[2] = DIFF_W'(s_point_z) - DIFF_W'(origin_z);
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            coef[0][c] = $signed(rot_row0[c*COEF_W +: COEF_W]);
            coef[1][c] = $signed(rot_row1[c*COEF_W +: COEF_W]);
            coef[2][c] = $signed(rot_row2[c*COEF_W +: COEF_W]);
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod_b_next[r][c] = coef[r][c] * diff_a_reg[c];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc[r] = ACC_W'(prod_b_reg[r][0]) + ACC_W'(prod_b_reg[r][1])
                   + ACC_W'(prod_b_reg[r][2]);
            loc[r] = sat_coord(round_frac(SAT_W'(acc[r])));
        end
        job_c_next.cmd    = cmd_b_reg;
        job_c_next.loc_x  = loc[0];
        job_c_next.loc_y  = loc[1];
        job_c_next.loc_z  = loc[2];
        job_c_next.amount = amt_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
            va_reg     <= 1'b0;
            vb_reg     <= 1'b0;
            vc_reg     <= 1'b0;
        end else begin
            credit_reg <= credit_next;
            va_reg     <= accept;
            vb_reg     <= va_reg;
            vc_reg     <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_a_reg <= cmd_t'(s_command);
            amt_a_reg <= s_amount;
            for (int c = 0; c < 3; c++) begin
                diff_a_reg[c] <= diff_a_next[c];
            end
        end
        if (va_reg) begin
            cmd_b_reg <= cmd_a_reg;
            amt_b_reg <= amt_a_reg;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_b_reg[r][c] <= prod_b_next[r][c];
                end
            end
        end
        if (vb_reg) begin
            job_c_reg <= job_c_next;
        end
    end

    assign job_push = vc_reg;
    assign job_out  = job_c_reg;

endmodule

// ===== hw/rtl/obx_fifo.sv =====
// Short queue of classified items between the transform pipeline and the box update.
module obx_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  obx_pkg::job_t       push_data,
    input  logic                pop,
    output obx_pkg::job_t       head,
    output obx_pkg::fifo_stat_t stat
);
    import obx_pkg::*;

    job_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;

    function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
        if (p == FIFO_AW'(FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + FIFO_AW'(1);
    endfunction

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + FIFO_CW'(1);
        end else if (!push && pop) begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!stat.full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !stat.empty)
        else $error("queue read while empty");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + FIFO_CW'(1)))
        else $error("queue count lost a write");
`endif

endmodule

// ===== hw/rtl/obx_back.sv =====
// Back end: applies queued items to the stored bounds and holds the result register.
module obx_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  obx_pkg::job_t       head,
    input  obx_pkg::fifo_stat_t stat,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output obx_pkg::coord_t     m_low_x,
    output obx_pkg::coord_t     m_high_x,
    output obx_pkg::coord_t     m_low_y,
    output obx_pkg::coord_t     m_high_y,
    output obx_pkg::coord_t     m_low_z,
    output obx_pkg::coord_t     m_high_z,
    output logic                m_box_is_valid,
    output logic                m_inside_res
);
    import obx_pkg::*;

    typedef enum logic [1:0] {
        BK_RUN = 2'b01,
        BK_MUL = 2'b10
    } bk_state_t;

    bk_state_t                 state_reg;
    bk_state_t                 state_next;
    coord_t                    lo_reg   [3];
    coord_t                    lo_next  [3];
    coord_t                    hi_reg   [3];
    coord_t                    hi_next  [3];
    logic                      box_valid_reg;
    logic                      box_valid_next;
    logic                      inside_reg;
    logic                      inside_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [IPROD_W-1:0] iprod_reg  [3];
    logic signed [IPROD_W-1:0] iprod_next [3];
    logic                      mul_go;

    logic                      out_free;
    logic                      head_ok;
    coord_t                    loc  [3];
    logic signed [EXT_W-1:0]   ext  [3];
    logic signed [SAT_W-1:0]   dlt  [3];
    logic                      in_box;

    assign out_free = !out_valid_reg || m_ready;
    assign head_ok  = !stat.empty;
    assign loc[0]   = head.loc_x;
    assign loc[1]   = head.loc_y;
    assign loc[2]   = head.loc_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            ext[a]        = EXT_W'(hi_reg[a]) - EXT_W'(lo_reg[a]);
            iprod_next[a] = head.amount * ext[a];
            dlt[a]        = round_frac(SAT_W'(iprod_reg[a]));
        end
    end

    always_comb begin
        state_next     = state_reg;
        pop            = 1'b0;
        mul_go         = 1'b0;
        box_valid_next = box_valid_reg;
        inside_next    = inside_reg;
        in_box         = 1'b1;
        for (int a = 0; a < 3; a++) begin
            lo_next[a] = lo_reg[a];
            hi_next[a] = hi_reg[a];
            if (loc[a] < lo_reg[a] || loc[a] > hi_reg[a]) begin
                in_box = 1'b0;
            end
        end

        case (state_reg)
            BK_RUN: begin
                if (head_ok && head.cmd == CMD_INFLATE) begin
                    // The extent product is registered before the bounds move.
                    mul_go     = 1'b1;
                    state_next = BK_MUL;
                end else if (head_ok && out_free) begin
                    pop         = 1'b1;
                    inside_next = 1'b0;
                    case (head.cmd)
                        CMD_ADD: begin
                            for (int a = 0; a < 3; a++) begin
                                if (!box_valid_reg || loc[a] < lo_reg[a]) begin
                                    lo_next[a] = loc[a];
                                end
                                if (!box_valid_reg || loc[a] > hi_reg[a]) begin
                                    hi_next[a] = loc[a];
                                end
                            end
                            box_valid_next = 1'b1;
                        end
                        CMD_TEST: begin
                            inside_next = in_box;
                        end
                        CMD_GROW: begin
                            for (int a = 0; a < 3; a++) begin
                                lo_next[a] = sat_coord(SAT_W'(lo_reg[a]) - SAT_W'(head.amount));
                                hi_next[a] = sat_coord(SAT_W'(hi_reg[a]) + SAT_W'(head.amount));
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_MUL: begin
                if (out_free) begin
                    pop         = 1'b1;
                    inside_next = 1'b0;
                    state_next  = BK_RUN;
                    for (int a = 0; a < 3; a++) begin
                        lo_next[a] = sat_coord(SAT_W'(lo_reg[a]) - dlt[a]);
                        hi_next[a] = sat_coord(SAT_W'(hi_reg[a]) + dlt[a]);
                    end
                end
            end
            default: begin
                state_next = BK_RUN;
            end
        endcase

        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_RUN;
            box_valid_reg <= 1'b0;
            inside_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                lo_reg[a] <= '0;
                hi_reg[a] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            box_valid_reg <= box_valid_next;
            inside_reg    <= inside_next;
            out_valid_reg <= out_valid_next;
            for (int a = 0; a < 3; a++) begin
                lo_reg[a] <= lo_next[a];
                hi_reg[a] <= hi_next[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_go) begin
            for (int a = 0; a < 3; a++) begin
                iprod_reg[a] <= iprod_next[a];
            end
        end
    end

    // The bounds only change when a result is loaded, so they are the result fields.
    assign m_valid        = out_valid_reg;
    assign m_low_x        = lo_reg[0];
    assign m_high_x       = hi_reg[0];
    assign m_low_y        = lo_reg[1];
    assign m_high_y       = hi_reg[1];
    assign m_low_z        = lo_reg[2];
    assign m_high_z       = hi_reg[2];
    assign m_box_is_valid = box_valid_reg;
    assign m_inside_res   = inside_reg;

endmodule

// ===== hw/rtl/oriented_box_accumulator.sv =====
// Top level of the oriented box accumulator: configuration registers and the front/back split.
// Path: three transform stages, the queue, then the result registers (inflate adds BK_MUL).
// Throughput: one item per cycle while results are taken; inflate items also wait in BK_MUL.
// The input stalls only while eight items sit between acceptance and the box update.
// Synchronous reset clears the bounds, the valid flag and the queue, and restores the
// register reset values: the packed rotation rows and a zero origin.
module oriented_box_accumulator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [obx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [obx_pkg::ROW_W-1:0]      cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [obx_pkg::CMD_W-1:0]      s_command,
    input  obx_pkg::coord_t                s_point_x,
    input  obx_pkg::coord_t                s_point_y,
    input  obx_pkg::coord_t                s_point_z,
    input  obx_pkg::amount_t               s_amount,
    output logic                           m_valid,
    input  logic                           m_ready,
    output obx_pkg::coord_t                m_low_x,
    output obx_pkg::coord_t                m_high_x,
    output obx_pkg::coord_t                m_low_y,
    output obx_pkg::coord_t                m_high_y,
    output obx_pkg::coord_t                m_low_z,
    output obx_pkg::coord_t                m_high_z,
    output logic                           m_box_is_valid,
    output logic                           m_inside_res
);
    import obx_pkg::*;

    // Frame configuration. The user must change it only while the block is idle; the block
    // does not enforce this. The pipeline reads it directly without any shadow copies.
    rot_row_t rot_row0_reg;
    rot_row_t rot_row1_reg;
    rot_row_t rot_row2_reg;
    coord_t   origin_x_reg;
    coord_t   origin_y_reg;
    coord_t   origin_z_reg;

    logic       job_push;
    logic       job_pop;
    job_t       job_in;
    job_t       job_head;
    fifo_stat_t fifo_stat;

    // Writes to an index past the last register fall into the default arm and are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_row0_reg <= ROT_ROW0_RST;
            rot_row1_reg <= ROT_ROW1_RST;
            rot_row2_reg <= ROT_ROW2_RST;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                REG_ROT_ROW0: rot_row0_reg <= cfg_wr_data;
                REG_ROT_ROW1: rot_row1_reg <= cfg_wr_data;
                REG_ROT_ROW2: rot_row2_reg <= cfg_wr_data;
                REG_ORIGIN_X: origin_x_reg <= cfg_wr_data[COORD_W-1:0];
                REG_ORIGIN_Y: origin_y_reg <= cfg_wr_data[COORD_W-1:0];
                REG_ORIGIN_Z: origin_z_reg <= cfg_wr_data[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front translates and rotates every point in three stages and tags it
    // with its command; it never stalls because it only accepts against credit.
    obx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_point_x (s_point_x),
        .s_point_y (s_point_y),
        .s_point_z (s_point_z),
        .s_amount  (s_amount),
        .rot_row0  (rot_row0_reg),
        .rot_row1  (rot_row1_reg),
        .rot_row2  (rot_row2_reg),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .origin_z  (origin_z_reg),
        .job_pop   (job_pop),
        .job_push  (job_push),
        .job_out   (job_in)
    );

    // The queue decouples the transform from the box update and the result handshake.
    obx_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .head      (job_head),
        .stat      (fifo_stat)
    );

    // The back end updates the box one item at a time and presents the bounds as the result.
    obx_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (job_head),
        .stat           (fifo_stat),
        .pop            (job_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_low_x        (m_low_x),
        .m_high_x       (m_high_x),
        .m_low_y        (m_low_y),
        .m_high_y       (m_high_y),
        .m_low_z        (m_low_z),
        .m_high_z       (m_high_z),
        .m_box_is_valid (m_box_is_valid),
        .m_inside_res   (m_inside_res)
    );

endmodule

// ===== verif/obx_box_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the oriented box accumulator: tracks configuration, predicts every result, compares.
module obx_box_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [obx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [obx_pkg::ROW_W-1:0]      cfg_wr_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [obx_pkg::CMD_W-1:0]      s_command,
    input  obx_pkg::coord_t                s_point_x,
    input  obx_pkg::coord_t                s_point_y,
    input  obx_pkg::coord_t                s_point_z,
    input  obx_pkg::amount_t               s_amount,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  obx_pkg::coord_t                m_low_x,
    input  obx_pkg::coord_t                m_high_x,
    input  obx_pkg::coord_t                m_low_y,
    input  obx_pkg::coord_t                m_high_y,
    input  obx_pkg::coord_t                m_low_z,
    input  obx_pkg::coord_t                m_high_z,
    input  logic                           m_box_is_valid,
    input  logic                           m_inside_res,
    output int                             mismatch_count,
    output int                             views_outstanding
);
    import obx_pkg::*;

    typedef struct packed {
        coord_t low_x;
        coord_t high_x;
        coord_t low_y;
        coord_t high_y;
        coord_t low_z;
        coord_t high_z;
        logic   box_is_valid;
        logic   inside_res;
    } box_view_t;

    localparam longint COORD_MAX    = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN    = -COORD_MAX - 1;
    localparam int     REPORT_LIMIT = 10;

    rot_row_t  rot_rows [3];
    coord_t    frame_origin [3];
    longint    bound_lo [3];
    longint    bound_hi [3];
    bit        box_filled;
    box_view_t awaited_views [$];

    // Drop the fraction bits, ties rounded toward plus infinity.
    function automatic longint drop_frac(input longint v);
        return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // One coordinate of the point in the local frame: exact dot product, then round and clamp.
    function automatic longint local_axis(input int r, input coord_t px, input coord_t py,
                                          input coord_t pz);
        logic signed [COEF_W-1:0] k;
        coord_t pt [3];
        longint acc;
        int c;
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        acc = 0;
        for (c = 0; c < 3; c++) begin
            k = rot_rows[r][c*COEF_W +: COEF_W];
            acc += longint'(k) * (longint'(pt[c]) - longint'(frame_origin[c]));
        end
        return clamp_coord(drop_frac(acc));
    endfunction

    // Applies one item to the tracked box and returns the view the block should report.
    function automatic box_view_t next_box_view(input cmd_t cmd, input coord_t px,
                                                input coord_t py, input coord_t pz,
                                                input amount_t amt);
        box_view_t view;
        longint loc;
        longint stretch;
        bit hit;
        int a;
        hit = 1'b0;
        case (cmd)
            CMD_ADD: begin
                for (a = 0; a < 3; a++) begin
                    loc = local_axis(a, px, py, pz);
                    if (!box_filled || loc < bound_lo[a]) bound_lo[a] = loc;
                    if (!box_filled || loc > bound_hi[a]) bound_hi[a] = loc;
                end
                box_filled = 1'b1;
            end
            CMD_TEST: begin
                hit = 1'b1;
                for (a = 0; a < 3; a++) begin
                    loc = local_axis(a, px, py, pz);
                    if (loc < bound_lo[a] || loc > bound_hi[a]) hit = 1'b0;
                end
            end
            CMD_GROW: begin
                for (a = 0; a < 3; a++) begin
                    bound_lo[a] = clamp_coord(bound_lo[a] - longint'(amt));
                    bound_hi[a] = clamp_coord(bound_hi[a] + longint'(amt));
                end
            end
            CMD_INFLATE: begin
                for (a = 0; a < 3; a++) begin
                    stretch = drop_frac(longint'(amt) * (bound_hi[a] - bound_lo[a]));
                    bound_lo[a] = clamp_coord(bound_lo[a] - stretch);
                    bound_hi[a] = clamp_coord(bound_hi[a] + stretch);
                end
            end
            default: ;
        endcase
        view.low_x        = coord_t'(bound_lo[0]);
        view.high_x       = coord_t'(bound_hi[0]);
        view.low_y        = coord_t'(bound_lo[1]);
        view.high_y       = coord_t'(bound_hi[1]);
        view.low_z        = coord_t'(bound_lo[2]);
        view.high_z       = coord_t'(bound_hi[2]);
        view.box_is_valid = box_filled;
        view.inside_res   = hit;
        return view;
    endfunction

    always @(posedge aclk) begin : watch
        box_view_t got;
        box_view_t want;
        int a;
        if (!aresetn) begin
            rot_rows[0] = ROT_ROW0_RST;
            rot_rows[1] = ROT_ROW1_RST;
            rot_rows[2] = ROT_ROW2_RST;
            for (a = 0; a < 3; a++) begin
                frame_origin[a] = '0;
                bound_lo[a]     = 0;
                bound_hi[a]     = 0;
            end
            box_filled     = 1'b0;
            mismatch_count = 0;
            awaited_views.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    REG_ROT_ROW0: rot_rows[0]     = cfg_wr_data;
                    REG_ROT_ROW1: rot_rows[1]     = cfg_wr_data;
                    REG_ROT_ROW2: rot_rows[2]     = cfg_wr_data;
                    REG_ORIGIN_X: frame_origin[0] = cfg_wr_data[COORD_W-1:0];
                    REG_ORIGIN_Y: frame_origin[1] = cfg_wr_data[COORD_W-1:0];
                    REG_ORIGIN_Z: frame_origin[2] = cfg_wr_data[COORD_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                awaited_views.push_back(next_box_view(cmd_t'(s_command), s_point_x,
                                                      s_point_y, s_point_z, s_amount));
            end
            if (m_valid && m_ready) begin
                got = {m_low_x, m_high_x, m_low_y, m_high_y, m_low_z, m_high_z,
                       m_box_is_valid, m_inside_res};
                if (awaited_views.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result with no item waiting for it", $time);
                end else begin
                    want = awaited_views.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("%0t: box result differs", $time);
                            $display("  expected x %h..%h y %h..%h z %h..%h valid %b inside %b",
                                     want.low_x, want.high_x, want.low_y, want.high_y,
                                     want.low_z, want.high_z, want.box_is_valid,
                                     want.inside_res);
                            $display("  actual   x %h..%h y %h..%h z %h..%h valid %b inside %b",
                                     got.low_x, got.high_x, got.low_y, got.high_y,
                                     got.low_z, got.high_z, got.box_is_valid,
                                     got.inside_res);
                        end
                    end
                end
            end
        end
        views_outstanding <= awaited_views.size();
    end

endmodule

// ===== verif/tb_oriented_box_accumulator.sv =====
`timescale 1ns / 1ps
// Top of the oriented box accumulator testbench: clock, reset, stimulus, back-pressure and verdict.
module tb_oriented_box_accumulator;

    import obx_pkg::*;

    typedef logic signed [COEF_W-1:0] coef_t;

    // Fixed-point landmarks used by the directed items.
    localparam coord_t C_MAX  = 32'sh7FFF_FFFF;
    localparam coord_t C_MIN  = 32'sh8000_0000;
    localparam coord_t Q_ONE  = 32'sh0001_0000;
    localparam coord_t Q_HALF = 32'sh0000_8000;

    // Rotation coefficients in Q2.16.
    localparam coef_t K_ZERO    = 18'sh00000;
    localparam coef_t K_ONE     = 18'sh10000;
    localparam coef_t K_NEG_ONE = -18'sh10000;
    localparam coef_t K_HALF    = 18'sh08000;
    localparam coef_t K_MAX     = 18'sh1FFFF;
    localparam coef_t K_MIN     = 18'sh20000;

    // The index port is three bits wide, but only six registers exist behind it.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int IDLE_PERCENT    = 28;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 225;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0]     cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command;
    coord_t               s_point_x;
    coord_t               s_point_y;
    coord_t               s_point_z;
    amount_t              s_amount;
    logic                 m_valid;
    logic                 m_ready;
    coord_t               m_low_x;
    coord_t               m_high_x;
    coord_t               m_low_y;
    coord_t               m_high_y;
    coord_t               m_low_z;
    coord_t               m_high_z;
    logic                 m_box_is_valid;
    logic                 m_inside_res;

    int mismatch_count;
    int views_outstanding;

    // When steady is set neither side idles; hold_off_req asks the result side for a long stall.
    bit steady;
    bit hold_off_req;

    oriented_box_accumulator DUT (.*);

    obx_box_checker box_check (.*);

    // 8 ns clock, low half first so that the first rising edge falls after time zero.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Packs three Q2.16 coefficients into one rotation row, column 0 in the low bits.
    function automatic rot_row_t pack_row(input coef_t c0, input coef_t c1, input coef_t c2);
        return {c2, c1, c0};
    endfunction

    // Origin registers take only the low 32 bits; the upper bits get random junk on purpose.
    function automatic rot_row_t padded_origin(input coord_t o);
        rot_row_t v;
        v = rot_row_t'({$urandom, $urandom});
        v[COORD_W-1:0] = o;
        return v;
    endfunction

    // A coordinate within about +/-256.0, where boxes stay small enough for tests to split.
    function automatic coord_t random_small();
        return coord_t'(int'($urandom_range(1 << 25)) - (1 << 24));
    endfunction

    function automatic rot_row_t random_row();
        return rot_row_t'({$urandom, $urandom});
    endfunction

    // A register write keeps the enable high; the caller lowers it when the burst is over,
    // so back-to-back writes never lower and raise the enable in the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input rot_row_t data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    // Writes all six registers: the three rotation rows, then the origin.
    task automatic load_frame(input rot_row_t r0, input rot_row_t r1, input rot_row_t r2,
                              input coord_t ox, input coord_t oy, input coord_t oz);
        write_reg(REG_ROT_ROW0, r0);
        write_reg(REG_ROT_ROW1, r1);
        write_reg(REG_ROT_ROW2, r2);
        write_reg(REG_ORIGIN_X, padded_origin(ox));
        write_reg(REG_ORIGIN_Y, padded_origin(oy));
        write_reg(REG_ORIGIN_Z, padded_origin(oz));
        cfg_wr_en <= 1'b0;
    endtask

    // Stops offering items and waits until every expected result has come back. The checker
    // publishes its count with a nonblocking update, so it is read no earlier than the edge
    // after the last acceptance.
    task automatic drain_box();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
            waited++;
        end while (views_outstanding != 0 && waited < DRAIN_LIMIT);
    endtask

    // Offers one item and returns at the edge where it is accepted. Random idle cycles
    // go before the item, so gaps land on every phase of the block's work.
    task automatic offer(input cmd_t cmd, input coord_t px, input coord_t py,
                         input coord_t pz, input amount_t amt);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_point_x <= px;
        s_point_y <= py;
        s_point_z <= pz;
        s_amount  <= amt;
        do @(posedge aclk); while (!s_ready);
    endtask

    // One random item. Points are mostly small so boxes and tests interact; a share of
    // full-range values reaches the saturation paths and toggles every bit. Grow offsets
    // and inflate factors are mostly small and lean positive, with both signs present.
    task automatic offer_random();
        cmd_t    cmd;
        coord_t  pt [3];
        amount_t amt;
        int      pick;
        int      i;
        pick = $urandom_range(99);
        if (pick < 40)
            cmd = CMD_ADD;
        else if (pick < 75)
            cmd = CMD_TEST;
        else if (pick < 88)
            cmd = CMD_GROW;
        else
            cmd = CMD_INFLATE;
        for (i = 0; i < 3; i++)
            pt[i] = ($urandom_range(99) < 15) ? coord_t'($urandom) : random_small();
        if ($urandom_range(99) < 10 || cmd == CMD_ADD || cmd == CMD_TEST)
            amt = amount_t'($urandom);
        else if (cmd == CMD_GROW)
            amt = amount_t'(int'($urandom_range(1 << 18)) - (1 << 16));
        else
            amt = amount_t'(int'($urandom_range(1 << 14)) - (1 << 12));
        offer(cmd, pt[0], pt[1], pt[2], amt);
    endtask

    // Result side. It stalls at random, never while steady is set, and on request holds off
    // for a long stretch so that the internal queue fills and the input side stalls too.
    initial begin : result_sink
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                m_ready <= 1'b1;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_command    = CMD_ADD;
        s_point_x    = '0;
        s_point_y    = '0;
        s_point_z    = '0;
        s_amount     = '0;
        steady       = 1'b0;
        hold_off_req = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items on the reset frame. The box starts empty with all bounds at zero,
        // so a test of the origin passes before any point was added.
        offer(CMD_TEST, '0, '0, '0, '0);
        offer(CMD_TEST, '0, Q_ONE, '0, '0);
        // Grow and inflate act on the empty box's stored bounds and leave it empty.
        offer(CMD_GROW, '0, '0, '0, '0);
        offer(CMD_INFLATE, '0, '0, '0, Q_ONE);
        // A negative grow turns the bounds inside out; the next test must fail.
        offer(CMD_GROW, '0, '0, '0, -32'sd1);
        offer(CMD_TEST, '0, '0, '0, '0);
        // The first add overwrites all six bounds, inverted or not.
        offer(CMD_ADD, C_MAX, C_MAX, C_MAX, '0);
        offer(CMD_ADD, C_MIN, C_MIN, C_MIN, '0);
        offer(CMD_TEST, '0, '0, '0, '0);
        offer(CMD_TEST, C_MAX, C_MIN, C_MAX, '0);
        // Extreme amounts drive the bounds into saturation in both directions.
        offer(CMD_GROW, '0, '0, '0, C_MAX);
        offer(CMD_INFLATE, '0, '0, '0, C_MIN);
        offer(CMD_TEST, '0, '0, '0, '0);
        offer(CMD_INFLATE, '0, '0, '0, C_MAX);
        offer(CMD_GROW, '0, '0, '0, C_MIN);

        // Writes to the two indexes past the register list must change nothing. Then a
        // frame of extreme coefficients and origins makes the transform saturate.
        drain_box();
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        load_frame(pack_row(K_MAX, K_MAX, K_MAX), pack_row(K_MIN, K_MIN, K_MIN), '1,
                   C_MAX, C_MIN, '0);
        offer(CMD_ADD, C_MIN, C_MAX, C_MAX, '0);
        offer(CMD_ADD, C_MAX, C_MIN, C_MIN, '0);
        offer(CMD_TEST, '0, '0, '0, '0);
        offer(CMD_INFLATE, '0, '0, '0, Q_HALF);
        offer(CMD_GROW, '0, '0, '0, Q_ONE);
        offer(CMD_TEST, C_MAX, C_MAX, C_MAX, '0);
        offer(CMD_ADD, Q_ONE, -Q_ONE, '0, '0);

        // Random phases, each on its own frame. The sender pauses before every frame change
        // until all results are back, so registers only move while the block is idle.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_box();
            case (phase)
                0: load_frame(pack_row(K_ONE, K_ZERO, K_ZERO), pack_row(K_ZERO, K_ONE, K_ZERO),
                              pack_row(K_ZERO, K_ZERO, K_ONE), '0, '0, '0);
                1: load_frame(random_row(), random_row(), random_row(),
                              random_small(), random_small(), random_small());
                // Quarter turn about z, origin x and y at the ends of the coordinate range.
                2: load_frame(pack_row(K_ZERO, K_ONE, K_ZERO),
                              pack_row(K_NEG_ONE, K_ZERO, K_ZERO),
                              pack_row(K_ZERO, K_ZERO, K_ONE), C_MAX, C_MIN, random_small());
                // All-zero rows map every point onto the local origin.
                3: load_frame('0, '0, '0, '0, '0, '0);
                4: load_frame(random_row(), random_row(), random_row(),
                              coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
                5: load_frame('1, '1, '1, C_MIN, C_MIN, C_MIN);
                6: load_frame(pack_row(K_MAX, K_MAX, K_MAX), pack_row(K_MAX, K_MAX, K_MAX),
                              pack_row(K_MAX, K_MAX, K_MAX), C_MAX, C_MAX, C_MAX);
                default: load_frame(pack_row(K_MIN, K_ZERO, K_ZERO),
                                    pack_row(K_ZERO, K_HALF, K_ZERO),
                                    pack_row(K_ZERO, K_ZERO, K_NEG_ONE),
                                    random_small(), random_small(), random_small());
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Long receiver stalls while the sender keeps offering items.
                if ((phase == 2 && n == 60) || (phase == 6 && n == 100))
                    hold_off_req = 1'b1;
                // A stretch where both sides run flat out.
                steady = (phase == 4 && n >= 40 && n < 200);
                offer_random();
            end
            steady = 1'b0;
        end

        // Wait for the last results, then a few more cycles to catch anything spurious.
        drain_box();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && views_outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // A hung handshake ends the run here; a correct run needs a small part of this time.
    initial begin : watchdog
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/obx_pkg.sv
hw/rtl/obx_front.sv
hw/rtl/obx_fifo.sv
hw/rtl/obx_back.sv
hw/rtl/oriented_box_accumulator.sv
verif/obx_box_checker.sv
verif/tb_oriented_box_accumulator.sv
